// ----- rtl/msd_pkg.sv -----
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, constants and the code book of the Morse signal decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int TICK_W         = 24;
	localparam int CFG_IDX_W      = 2;
	localparam int CHAR_W         = 7;
	localparam int CODE_W         = 7;
	localparam int LEN_W          = 3;
	localparam int MAX_SYMBOLS_DEF  = 512;
	localparam int MAX_CODE_LEN_DEF = 7;

	localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DOT_TICKS    = 2'd0,
		CFG_LETTER_GAP   = 2'd1,
		CFG_WORD_GAP     = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} msd_res_t;

	// Look up a finished letter: dashes are 1, first symbol in the top used bit.
	function automatic logic [CHAR_W-1:0] code_lookup(input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] bits);
		logic [CHAR_W-1:0] ch;
		ch = CHAR_UNKNOWN;
		unique case ({len, bits})
			{3'd2, 7'd1}:  ch = 7'h41; // A
			{3'd4, 7'd8}:  ch = 7'h42; // B
			{3'd4, 7'd10}: ch = 7'h43; // C
			{3'd3, 7'd4}:  ch = 7'h44; // D
			{3'd1, 7'd0}:  ch = 7'h45; // E
			{3'd4, 7'd2}:  ch = 7'h46; // F
			{3'd3, 7'd6}:  ch = 7'h47; // G
			{3'd4, 7'd0}:  ch = 7'h48; // H
			{3'd2, 7'd0}:  ch = 7'h49; // I
			{3'd4, 7'd7}:  ch = 7'h4A; // J
			{3'd3, 7'd5}:  ch = 7'h4B; // K
			{3'd4, 7'd4}:  ch = 7'h4C; // L
			{3'd2, 7'd3}:  ch = 7'h4D; // M
			{3'd2, 7'd2}:  ch = 7'h4E; // N
			{3'd3, 7'd7}:  ch = 7'h4F; // O
			{3'd4, 7'd6}:  ch = 7'h50; // P
			{3'd4, 7'd13}: ch = 7'h51; // Q
			{3'd3, 7'd2}:  ch = 7'h52; // R
			{3'd3, 7'd0}:  ch = 7'h53; // S
			{3'd1, 7'd1}:  ch = 7'h54; // T
			{3'd3, 7'd1}:  ch = 7'h55; // U
			{3'd4, 7'd1}:  ch = 7'h56; // V
			{3'd3, 7'd3}:  ch = 7'h57; // W
			{3'd4, 7'd9}:  ch = 7'h58; // X
			{3'd4, 7'd11}: ch = 7'h59; // Y
			{3'd4, 7'd12}: ch = 7'h5A; // Z
			{3'd5, 7'd15}: ch = 7'h31; // 1
			{3'd5, 7'd7}:  ch = 7'h32; // 2
			{3'd5, 7'd3}:  ch = 7'h33; // 3
			{3'd5, 7'd1}:  ch = 7'h34; // 4
			{3'd5, 7'd0}:  ch = 7'h35; // 5
			{3'd5, 7'd16}: ch = 7'h36; // 6
			{3'd5, 7'd24}: ch = 7'h37; // 7
			{3'd5, 7'd28}: ch = 7'h38; // 8
			{3'd5, 7'd30}: ch = 7'h39; // 9
			{3'd5, 7'd31}: ch = 7'h30; // 0
			{3'd6, 7'd21}: ch = 7'h2E; // period
			{3'd6, 7'd51}: ch = 7'h2C; // comma
			{3'd6, 7'd12}: ch = 7'h3F; // question mark
			{3'd6, 7'd30}: ch = 7'h27; // apostrophe
			{3'd6, 7'd43}: ch = 7'h21; // exclamation
			{3'd5, 7'd18}: ch = 7'h2F; // slash
			{3'd5, 7'd22}: ch = 7'h28; // open paren
			{3'd6, 7'd45}: ch = 7'h29; // close paren
			{3'd5, 7'd8}:  ch = 7'h26; // ampersand
			{3'd6, 7'd56}: ch = 7'h3A; // colon
			{3'd6, 7'd42}: ch = 7'h3B; // semicolon
			{3'd5, 7'd17}: ch = 7'h3D; // equals
			{3'd5, 7'd10}: ch = 7'h2B; // plus
			{3'd6, 7'd33}: ch = 7'h2D; // hyphen
			{3'd6, 7'd13}: ch = 7'h5F; // underscore
			{3'd6, 7'd18}: ch = 7'h22; // double quote
			{3'd7, 7'd9}:  ch = 7'h24; // dollar
			{3'd6, 7'd26}: ch = 7'h40; // at sign
			default:       ch = CHAR_UNKNOWN;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/msd_sample_if.sv -----
// ----------------------------------------------------------------------------
// msd_sample_if
// Keying-line sample channel: valid/ready handshake with op and level.
// ----------------------------------------------------------------------------
interface msd_sample_if;
	logic valid;
	logic ready;
	logic op;
	logic level;

	modport source (output valid, output op, output level, input ready);
	modport sink (input valid, input op, input level, output ready);
endinterface

// ----- rtl/msd_text_if.sv -----
// ----------------------------------------------------------------------------
// msd_text_if
// Decoded text channel: valid/ready handshake with char_code and last.
// ----------------------------------------------------------------------------
interface msd_text_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/morse_signal_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// morse_signal_decoder_unit
// Decodes a sampled Morse keying line into ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one beat per tick, op selects a line sample or a text clear,
//            level is the keying line (1 = mark).
//   text   : decoded characters; a word end may give a letter and a space,
//            last marks the final beat caused by one sample.
//   cfg_*  : write port for dot_ticks, letter_gap_ticks and word_gap_ticks;
//            write only while no sample is in flight.
// Timing: a sample is registered on acceptance and, once the queue has
// room, decoded from that register straight into a four-entry result
// queue, from which its first character is offered. One sample is taken
// every cycle as long as the queue has room for two more beats; the text
// side drains one beat per cycle while the receiver is ready, so a stream
// that yields a character and a space per sample is paced by the text side.
// Reset clears all line and text state and loads the default thresholds.
// When the text receiver stalls, the queue fills and sample.ready drops
// until it has room again; nothing is lost.
// ----------------------------------------------------------------------------
module morse_signal_decoder_unit #(
	parameter int MAX_SYMBOLS  = msd_pkg::MAX_SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = msd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	msd_sample_if.sink                    sample,
	msd_text_if.source                    text,
	input  logic                          cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msd_pkg::TICK_W-1:0]    cfg_data
);
	import msd_pkg::*;

	localparam int SYM_W   = $clog2(MAX_SYMBOLS + 1);
	localparam int Q_DEPTH = 4;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	// configuration
	logic [TICK_W-1:0] dot_ticks_q, letter_gap_q, word_gap_q;

	// input register
	logic valid_s1, op_s1, level_s1;

	// decoder state
	logic              started_q, prev_level_q;
	logic [TICK_W-1:0] run_ticks_q;
	logic [CODE_W-1:0] letter_bits_q;
	logic [LEN_W-1:0]  letter_len_q;
	logic              overlong_q, text_started_q;
	logic [SYM_W-1:0]  symbol_count_q;

	// result queue
	msd_res_t          queue_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              fire, pop, room;
	logic [TICK_W-1:0] run_inc;
	logic              changed, cap_ok, is_clear;
	logic              mark_end, word_end, letter_end;
	logic              pending, emit_letter, emit_space;
	logic              dash;
	logic [CHAR_W-1:0] letter_char;
	msd_res_t          res0, res1;
	logic [1:0]        n_res;

	assign room   = (cnt_q <= CNT_W'(Q_DEPTH - 2));
	assign fire   = valid_s1 && room;
	assign pop    = text.valid && text.ready;
	assign sample.ready = !valid_s1 || fire;

	assign text.valid     = (cnt_q != '0);
	assign text.char_code = queue_q[rd_ptr_q].char_code;
	assign text.last      = queue_q[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_ticks_q  <= TICK_W'(1000);
			letter_gap_q <= TICK_W'(1000);
			word_gap_q   <= TICK_W'(2000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DOT_TICKS:  dot_ticks_q  <= cfg_data;
				CFG_LETTER_GAP: letter_gap_q <= cfg_data;
				CFG_WORD_GAP:   word_gap_q   <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			op_s1    <= sample.op;
			level_s1 <= sample.level;
		end
	end

	// decode of the registered sample
	always_comb begin
		is_clear    = (op_s1 == OP_CLEAR);
		run_inc     = (run_ticks_q == '1) ? run_ticks_q : run_ticks_q + TICK_W'(1);
		changed     = !is_clear && started_q && (level_s1 != prev_level_q);
		cap_ok      = (symbol_count_q < SYM_W'(MAX_SYMBOLS));
		mark_end    = changed && prev_level_q && cap_ok;
		word_end    = changed && !prev_level_q && (run_inc > word_gap_q) && cap_ok;
		letter_end  = changed && !prev_level_q && !(run_inc > word_gap_q)
			&& (run_inc > letter_gap_q) && cap_ok;
		dash        = !(run_inc < dot_ticks_q);
		pending     = (letter_len_q != '0) || overlong_q;
		letter_char = overlong_q ? CHAR_UNKNOWN : code_lookup(letter_len_q, letter_bits_q);
		emit_letter = (word_end || letter_end) && pending;
		emit_space  = word_end && (text_started_q || pending);
		n_res       = {1'b0, emit_letter} + {1'b0, emit_space};
		res1        = msd_res_t'{char_code: CHAR_SPACE, last: 1'b1};
		res0        = emit_letter ? msd_res_t'{char_code: letter_char, last: !emit_space}
			: res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q      <= 1'b0;
			prev_level_q   <= 1'b0;
			run_ticks_q    <= '0;
			letter_bits_q  <= '0;
			letter_len_q   <= '0;
			overlong_q     <= 1'b0;
			text_started_q <= 1'b0;
			symbol_count_q <= '0;
		end else if (fire) begin
			priority if (is_clear) begin
				letter_bits_q  <= '0;
				letter_len_q   <= '0;
				overlong_q     <= 1'b0;
				text_started_q <= 1'b0;
				symbol_count_q <= '0;
			end else if (!started_q) begin
				started_q    <= 1'b1;
				prev_level_q <= level_s1;
				run_ticks_q  <= '0;
			end else if (!changed) begin
				run_ticks_q <= run_inc;
			end else begin
				run_ticks_q  <= '0;
				prev_level_q <= level_s1;
				if (mark_end || word_end || letter_end) begin
					symbol_count_q <= symbol_count_q + SYM_W'(1);
				end
				if (mark_end) begin
					if (letter_len_q < LEN_W'(MAX_CODE_LEN)) begin
						letter_bits_q <= {letter_bits_q[CODE_W-2:0], dash};
						letter_len_q  <= letter_len_q + LEN_W'(1);
					end else begin
						overlong_q <= 1'b1;
					end
				end
				if (word_end || letter_end) begin
					letter_bits_q <= '0;
					letter_len_q  <= '0;
					overlong_q    <= 1'b0;
				end
				if (emit_letter || emit_space) begin
					text_started_q <= 1'b1;
				end
			end
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (fire ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (n_res != 2'd0)) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (fire && (n_res == 2'd2)) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(Q_DEPTH))
		else $error("result queue overflow");

	a_letter_len: assert property (@(posedge clk) disable iff (!arst_n)
		letter_len_q <= LEN_W'(MAX_CODE_LEN))
		else $error("pending letter longer than the code limit");

	a_symbol_cap: assert property (@(posedge clk) disable iff (!arst_n)
		symbol_count_q <= SYM_W'(MAX_SYMBOLS))
		else $error("symbol count past its cap");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_clear |=> cnt_q <= $past(cnt_q))
		else $error("clear beat produced a result");

	a_no_push_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> $stable(wr_ptr_q))
		else $error("result written without queue room");

endmodule
